[src/ucc_pkg.sv]
// Shared types and constants for the Unix seconds / calendar date converter.
`timescale 1ns / 1ps
`default_nettype none

package ucc_pkg;

   localparam int STAGES = 9;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   localparam int SECS_W   = 40;
   localparam int YEAR_W   = 16;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int USECS_W  = 42;

   typedef enum logic {
      CMD_TO_DATE = 1'b0,
      CMD_TO_SECS = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } date_type;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAY_DIV       = 675;      // 86400 >> 7
   localparam int EPOCH_DAYS    = 719561;
   localparam int A_BIAS        = 102032;
   localparam int A_DIV         = 146097;
   localparam int A_ADD         = 15;
   localparam int JD_OFFSET     = 2442113;
   localparam int C_BIAS        = 2442;
   localparam int C_DIV         = 7305;
   localparam int DAYS_PER_YEAR = 365;
   localparam int E_NUM         = 1000;
   localparam int E_DIV         = 30601;
   localparam int F_NUM         = 601;
   localparam int MONTH_DAYS    = 30;
   localparam int LATE_MONTH    = 13;
   localparam int YEAR_LO       = 4716;
   localparam int YEAR_HI       = 4715;
   localparam int FEB           = 2;
   localparam int MONTHS        = 12;
   localparam int CENTURY       = 100;

   // reciprocal multipliers; floor form for the day split (corrected later),
   // ceiling form elsewhere, exact over the operand ranges used
   localparam int DAY_K = 41;
   localparam logic [31:0] DAY_M = 32'((64'd1 << DAY_K) / 64'(DAY_DIV));
   localparam int HOUR_K = 27;
   localparam logic [15:0] HOUR_M =
      16'(((64'd1 << HOUR_K) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
   localparam int MIN_K = 18;
   localparam logic [12:0] MIN_M =
      13'(((64'd1 << MIN_K) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
   localparam int A_K = 43;
   localparam logic [25:0] A_M =
      26'(((64'd1 << A_K) + 64'(A_DIV) - 64'd1) / 64'(A_DIV));
   localparam int C_K = 41;
   localparam logic [28:0] C_M =
      29'(((64'd1 << C_K) + 64'(C_DIV) - 64'd1) / 64'(C_DIV));
   localparam int E_K = 24;
   localparam logic [19:0] E_M =
      20'(((64'(E_NUM) << E_K) + 64'(E_DIV) - 64'd1) / 64'(E_DIV));
   localparam int F_K = 14;
   localparam logic [13:0] F_M =
      14'(((64'(F_NUM) << F_K) + 64'(E_NUM) - 64'd1) / 64'(E_NUM));
   localparam int Y100_K = 23;
   localparam logic [16:0] Y100_M =
      17'(((64'd1 << Y100_K) + 64'(CENTURY) - 64'd1) / 64'(CENTURY));

endpackage

`default_nettype wire

[src/ucc_s2d.sv]
// Seconds-to-date datapath: nine register stages, one word per cycle while every stage_load bit is set.
`timescale 1ns / 1ps
`default_nettype none

module ucc_s2d (
   input  logic                              clock,
   input  logic [ucc_pkg::STAGES-1:0]        stage_load,
   input  logic signed [ucc_pkg::SECS_W-1:0] unix_seconds,
   output ucc_pkg::date_type                 date
);
   import ucc_pkg::*;

   // stage 1: clamp, estimate day count
   logic [38:0] t;
   logic [63:0] day_prod;
   logic [22:0] qest_in, qest_ff;
   logic [10:0] xlo_ff;
   logic [6:0]  tlo1_ff;

   // stage 2: remainder estimate
   logic [32:0] qmul;
   logic [10:0] rest_in, rest_ff;
   logic [22:0] q2_ff;
   logic [6:0]  tlo2_ff;

   // stage 3: correction
   logic        fix;
   logic [10:0] rfix;
   logic [22:0] days_in, days3_ff;
   logic [16:0] sod_in, sod3_ff;

   // stage 4: hour, century term
   logic [32:0] hour_prod;
   logic [24:0] anum;
   logic [63:0] a_prod;
   logic [HOUR_W-1:0] hour4_ff, hour5_ff, hour6_ff, hour7_ff, hour8_ff;
   logic [16:0] sod4_ff;
   logic [22:0] days4_ff;
   logic [7:0]  aq4_ff;

   // stage 5: remainder of hour, shifted day number
   logic [16:0] hmul;
   logic [7:0]  aval;
   logic [11:0] rem_in, rem5_ff, rem6_ff;
   logic [23:0] b_in, b5_ff, b6_ff;

   // stage 6: minute, year estimate
   logic [24:0] min_prod;
   logic [27:0] cnum;
   logic [63:0] c_prod;
   logic [MINUTE_W-1:0] minute6_ff, minute7_ff, minute8_ff;
   logic [14:0] c6_ff, c7_ff, c8_ff;

   // stage 7: second, day of year
   logic [11:0] smul;
   logic [23:0] cmul;
   logic [SECOND_W-1:0] second7_ff, second8_ff;
   logic [8:0]  dd_in, dd7_ff, dd8_ff;

   // stage 8: month estimate
   logic [28:0] e_prod;
   logic [3:0]  e8_ff;

   // stage 9: day of month, final year and month
   logic [17:0] f_prod;
   logic [8:0]  emul;
   logic        late;
   date_type    date_in, date_ff;

   always_comb begin
      t        = unix_seconds[SECS_W-1] ? '0 : unix_seconds[38:0];
      day_prod = 64'(t[38:7]) * 64'(DAY_M);
      qest_in  = day_prod[DAY_K +: 23];
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         qest_ff <= qest_in;
         xlo_ff  <= t[17:7];
         tlo1_ff <= t[6:0];
      end
   end

   always_comb begin
      qmul    = 33'(qest_ff) * 33'(DAY_DIV);
      rest_in = xlo_ff - qmul[10:0];
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         q2_ff   <= qest_ff;
         rest_ff <= rest_in;
         tlo2_ff <= tlo1_ff;
      end
   end

   always_comb begin
      fix     = rest_ff >= 11'(DAY_DIV);
      days_in = fix ? q2_ff + 23'd1 : q2_ff;
      rfix    = fix ? rest_ff - 11'(DAY_DIV) : rest_ff;
      sod_in  = {rfix[9:0], tlo2_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         days3_ff <= days_in;
         sod3_ff  <= sod_in;
      end
   end

   always_comb begin
      hour_prod = 33'(sod3_ff) * 33'(HOUR_M);
      anum      = {days3_ff, 2'b00} + 25'(A_BIAS);
      a_prod    = 64'(anum) * 64'(A_M);
   end

   always_ff @(posedge clock) begin
      if (stage_load[3]) begin
         hour4_ff <= hour_prod[HOUR_K +: HOUR_W];
         sod4_ff  <= sod3_ff;
         days4_ff <= days3_ff;
         aq4_ff   <= a_prod[A_K +: 8];
      end
   end

   always_comb begin
      hmul   = 17'(hour4_ff) * 17'(SECS_PER_HOUR);
      rem_in = sod4_ff[11:0] - hmul[11:0];
      aval   = aq4_ff + 8'(A_ADD);
      b_in   = 24'(days4_ff) + 24'(JD_OFFSET) + 24'(aval) - 24'(aval[7:2]);
   end

   always_ff @(posedge clock) begin
      if (stage_load[4]) begin
         hour5_ff <= hour4_ff;
         rem5_ff  <= rem_in;
         b5_ff    <= b_in;
      end
   end

   always_comb begin
      min_prod = 25'(rem5_ff) * 25'(MIN_M);
      cnum     = 28'({b5_ff, 4'b0000}) + 28'({b5_ff, 2'b00}) - 28'(C_BIAS);
      c_prod   = 64'(cnum) * 64'(C_M);
   end

   always_ff @(posedge clock) begin
      if (stage_load[5]) begin
         hour6_ff   <= hour5_ff;
         rem6_ff    <= rem5_ff;
         minute6_ff <= min_prod[MIN_K +: MINUTE_W];
         b6_ff      <= b5_ff;
         c6_ff      <= c_prod[C_K +: 15];
      end
   end

   always_comb begin
      smul  = 12'(minute6_ff) * 12'(SECS_PER_MIN);
      cmul  = 24'(c6_ff) * 24'(DAYS_PER_YEAR);
      dd_in = b6_ff[8:0] - cmul[8:0] - 9'(c6_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (stage_load[6]) begin
         hour7_ff   <= hour6_ff;
         minute7_ff <= minute6_ff;
         second7_ff <= rem6_ff[5:0] - smul[5:0];
         c7_ff      <= c6_ff;
         dd7_ff     <= dd_in;
      end
   end

   assign e_prod = 29'(dd7_ff) * 29'(E_M);

   always_ff @(posedge clock) begin
      if (stage_load[7]) begin
         hour8_ff   <= hour7_ff;
         minute8_ff <= minute7_ff;
         second8_ff <= second7_ff;
         c8_ff      <= c7_ff;
         dd8_ff     <= dd7_ff;
         e8_ff      <= e_prod[E_K +: 4];
      end
   end

   always_comb begin
      f_prod         = 18'(e8_ff) * 18'(F_M);
      emul           = 9'(e8_ff) * 9'(MONTH_DAYS);
      late           = e8_ff > 4'(LATE_MONTH);
      date_in.year   = 16'(c8_ff) - (late ? 16'(YEAR_HI) : 16'(YEAR_LO));
      date_in.month  = late ? e8_ff - 4'(LATE_MONTH) : e8_ff - 4'd1;
      date_in.day    = dd8_ff[4:0] - emul[4:0] - 5'(f_prod[F_K +: 4]);
      date_in.hour   = hour8_ff;
      date_in.minute = minute8_ff;
      date_in.second = second8_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_load[8]) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

`default_nettype wire

[src/ucc_d2s.sv]
// Date-to-seconds datapath: three working stages, then delay to match.
`timescale 1ns / 1ps
`default_nettype none

module ucc_d2s (
   input  logic                                clock,
   input  logic [ucc_pkg::STAGES-1:0]          stage_load,
   input  logic [ucc_pkg::YEAR_W-1:0]          year,
   input  logic [ucc_pkg::MONTH_W-1:0]         month,
   input  logic [ucc_pkg::DAY_W-1:0]           day,
   input  logic [ucc_pkg::HOUR_W-1:0]          hour,
   input  logic [ucc_pkg::MINUTE_W-1:0]        minute,
   input  logic [ucc_pkg::SECOND_W-1:0]        second,
   output logic [ucc_pkg::USECS_W-1:0]         secs
);
   import ucc_pkg::*;

   // day offset of the start of month m, month counted from March as 3
   function automatic logic [8:0] month_days(input logic [3:0] m);
      logic [3:0] frac;
      case (m) inside
         4'd0:               frac = 4'd0;
         4'd1, 4'd2:         frac = 4'd1;
         4'd3:               frac = 4'd2;
         4'd4, 4'd5:         frac = 4'd3;
         4'd6, 4'd7:         frac = 4'd4;
         4'd8:               frac = 4'd5;
         4'd9, 4'd10:        frac = 4'd6;
         4'd11, 4'd12:       frac = 4'd7;
         4'd13:              frac = 4'd8;
         default:            frac = 4'd9;
      endcase
      return 9'(m) * 9'(MONTH_DAYS) + 9'(frac);
   endfunction

   logic        low;
   logic        yneg_in, yneg_ff;
   logic [15:0] y_in, y_ff;
   logic [3:0]  m_adj;
   logic [32:0] y100_prod;
   logic [9:0]  q100_ff;
   logic [8:0]  md_in, md_ff;
   logic [16:0] tod_in, tod1_ff, tod2_ff;
   logic [25:0] y365;
   logic [25:0] ydays;
   logic [25:0] days_in, days_ff;
   logic [41:0] secs_in;
   logic [41:0] secs_ff [2:STAGES-1];

   always_comb begin
      low       = month <= 4'(FEB);
      yneg_in   = low && (year == '0);
      y_in      = low ? (yneg_in ? '0 : year - 16'd1) : year;
      m_adj     = low ? month + 4'(MONTHS) : month;
      y100_prod = 33'(y_in) * 33'(Y100_M);
      md_in     = month_days(m_adj) + 9'(day);
      tod_in    = 17'(hour) * 17'(SECS_PER_HOUR) + 17'(minute) * 17'(SECS_PER_MIN)
                  + 17'(second);
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         yneg_ff <= yneg_in;
         y_ff    <= y_in;
         q100_ff <= y100_prod[Y100_K +: 10];
         md_ff   <= md_in;
         tod1_ff <= tod_in;
      end
   end

   // year -1 truncates all leap terms to zero
   always_comb begin
      y365    = 26'(y_ff) * 26'(DAYS_PER_YEAR);
      ydays   = yneg_ff ? 26'd0 - 26'(DAYS_PER_YEAR)
                        : y365 + 26'(y_ff[15:2]) - 26'(q100_ff) + 26'(q100_ff[9:2]);
      days_in = ydays + 26'(md_ff) - 26'(EPOCH_DAYS);
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         days_ff <= days_in;
         tod2_ff <= tod1_ff;
      end
   end

   assign secs_in = 42'($signed(days_ff)) * 42'(SECS_PER_DAY) + 42'(tod2_ff);

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         secs_ff[2] <= secs_in;
      end
      for (int i = 3; i < STAGES; i++) begin
         if (stage_load[i]) begin
            secs_ff[i] <= secs_ff[i-1];
         end
      end
   end

   assign secs = secs_ff[STAGES-1];

endmodule

`default_nettype wire

[src/unix_calendar_converter.sv]
// Top level: Unix seconds / Gregorian date converter with stream handshakes.
//
// One request word in, one response word out. req_tuser selects the direction:
// 0 turns the signed seconds count into year, month, day and time of day
// (negative counts read as zero), 1 turns the date and time fields into
// seconds since the 1970 epoch. Fields not produced by the chosen direction
// read as zero in the response.
// Nine register stages: a word accepted into the first stage moves through the
// rest in order and is offered on rsp_tvalid from the last. One word per cycle
// is sustained while the receiver keeps rsp_tready high; the depth is set by the chained reciprocal multiplies of the
// date split (day count, century, year, month), each followed by a register.
// Each stage holds its own valid bit, so bubbles close up: when the receiver
// stalls, words back up stage by stage and req_tready falls only once all
// nine stages are full. Nothing is dropped or repeated.
// Reset clears the valid bits only, at the clock edge, and so empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module unix_calendar_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // unix_seconds, in_year, in_month, in_day, in_hour, in_minute, in_second
   input  logic [ucc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_year, out_month, out_day, out_hour, out_minute, out_second,
   // out_unix_seconds
   output logic [ucc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ucc_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in, load;
   cmd_type           cmd_ff [STAGES];
   date_type          date;
   logic [USECS_W-1:0] secs;
   logic              to_secs;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         cmd_ff[0] <= cmd_type'(req_tuser);
      end
      for (int i = 1; i < STAGES; i++) begin
         if (load[i]) begin
            cmd_ff[i] <= cmd_ff[i-1];
         end
      end
   end

   ucc_s2d u_s2d (
      .clock        (clock),
      .stage_load   (load),
      .unix_seconds ($signed(req_tdata[39:0])),
      .date         (date)
   );

   ucc_d2s u_d2s (
      .clock      (clock),
      .stage_load (load),
      .year       (req_tdata[55:40]),
      .month      (req_tdata[59:56]),
      .day        (req_tdata[64:60]),
      .hour       (req_tdata[69:65]),
      .minute     (req_tdata[75:70]),
      .second     (req_tdata[81:76]),
      .secs       (secs)
   );

   assign to_secs    = cmd_ff[STAGES-1] == CMD_TO_SECS;
   assign req_tready = load[0];
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {4'b0000,
                        to_secs ? secs : '0,
                        to_secs ? '0 : date.second,
                        to_secs ? '0 : date.minute,
                        to_secs ? '0 : date.hour,
                        to_secs ? '0 : date.day,
                        to_secs ? '0 : date.month,
                        to_secs ? '0 : date.year};

   a_date_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !to_secs |->
         date.month >= 4'd1 && date.month <= 4'd12 && date.day >= 5'd1
         && date.hour <= 5'd23 && date.minute <= 6'd59 && date.second <= 6'd59)
      else $error("date word out of range");

   a_date_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !to_secs |-> date.year >= 16'd1970)
      else $error("date word before epoch");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff) && !rsp_tready)
      else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire

[test/unix_calendar_converter_tb.sv]
// Self-checking testbench for the Unix seconds / calendar date converter.
`timescale 1ns / 1ps

module unix_calendar_converter_tb;
   import ucc_pkg::*;

   typedef struct {
      cmd_type               cmd;
      logic [SECS_W-1:0]     secs;
      logic [YEAR_W-1:0]     year;
      logic [MONTH_W-1:0]    month;
      logic [DAY_W-1:0]      day;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
      logic [SECOND_W-1:0]   second;
      bit                    wait_idle;  // hold this word until the pipe drains
   } conv_req_type;

   typedef struct {
      logic [YEAR_W-1:0]     year;
      logic [MONTH_W-1:0]    month;
      logic [DAY_W-1:0]      day;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
      logic [SECOND_W-1:0]   second;
      logic [USECS_W-1:0]    usecs;
   } conv_rsp_type;

   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   conv_req_type queued_requests[$];
   conv_rsp_type due_conversions[$];
   conv_req_type cur_req;
   conv_rsp_type want;
   conv_rsp_type got;

   int total_reqs;
   int accepted_cnt;
   int to_secs_cnt;
   int negative_cnt;
   int backpressure_cycles;
   int results_cnt;
   int mismatches;
   int burst_left;
   int gap_left;
   int hold_left;
   int mode_timer;
   int ready_mode;
   int taken_cnt;
   bit long_hold_done;

   unix_calendar_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic conv_rsp_type convert_calendar(input conv_req_type r);
      conv_rsp_type o;
      longint t, a, b, c, d, e, f;
      longint y, m, days, secs;
      o = '{default: '0};
      if (r.cmd == CMD_TO_SECS) begin
         y = longint'(r.year);
         m = longint'(r.month);
         if (m <= 2) begin
            m = m + 12;
            y = y - 1;
         end
         days = 365 * y + y / 4 - y / 100 + y / 400;
         days = days + 30 * m + (3 * (m + 1)) / 5 + longint'(r.day) - 719561;
         secs = days * 86400 + 3600 * longint'(r.hour) + 60 * longint'(r.minute)
                + longint'(r.second);
         o.usecs = secs[USECS_W-1:0];
      end else begin
         t = r.secs[SECS_W-1] ? 0 : longint'(r.secs);
         o.second = SECOND_W'(t % 60);
         t = t / 60;
         o.minute = MINUTE_W'(t % 60);
         t = t / 60;
         o.hour = HOUR_W'(t % 24);
         t = t / 24;
         a = (4 * t + 102032) / 146097 + 15;
         b = t + 2442113 + a - a / 4;
         c = (20 * b - 2442) / 7305;
         d = b - 365 * c - c / 4;
         e = d * 1000 / 30601;
         f = d - e * 30 - e * 601 / 1000;
         if (e <= 13) begin
            c = c - 4716;
            e = e - 1;
         end else begin
            c = c - 4715;
            e = e - 13;
         end
         o.year  = c[YEAR_W-1:0];
         o.month = e[MONTH_W-1:0];
         o.day   = f[DAY_W-1:0];
      end
      return o;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   task automatic queue_to_date(input logic [SECS_W-1:0] s);
      conv_req_type it;
      it = '{CMD_TO_DATE, s, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
             6'($urandom), 6'($urandom), 1'b0};
      queued_requests.push_back(it);
   endtask

   task automatic queue_to_secs(input int y, input int mo, input int d, input int h,
                                input int mi, input int s);
      conv_req_type it;
      it = '{CMD_TO_SECS, {8'($urandom), $urandom}, 16'(y), 4'(mo), 5'(d), 5'(h),
             6'(mi), 6'(s), 1'b0};
      queued_requests.push_back(it);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_conversions.push_back(convert_calendar(cur_req));
            accepted_cnt++;
            if (cur_req.cmd == CMD_TO_SECS)
               to_secs_cnt++;
            else if (cur_req.secs[SECS_W-1])
               negative_cnt++;
         end
         if (req_tvalid && !req_tready)
            backpressure_cycles++;
         if (!req_tvalid || req_tready) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() == 0 ||
                         (queued_requests[0].wait_idle && due_conversions.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               cur_req = queued_requests.pop_front();
               burst_left--;
               req_tvalid <= 1'b1;
               req_tuser  <= cur_req.cmd;
               req_tdata  <= {6'd0, cur_req.second, cur_req.minute, cur_req.hour,
                              cur_req.day, cur_req.month, cur_req.year, cur_req.secs};
            end
         end
      end
   end

   // receiver: stall pattern is redrawn at random each time mode_timer runs out, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_timer = 0;
         ready_mode = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            taken_cnt++;
         if (mode_timer == 0) begin
            mode_timer = 64;
            ready_mode = $urandom_range(0, 3);
         end
         mode_timer--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && taken_cnt >= 400) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_cnt++;
         got.year   = rsp_tdata[15:0];
         got.month  = rsp_tdata[19:16];
         got.day    = rsp_tdata[24:20];
         got.hour   = rsp_tdata[29:25];
         got.minute = rsp_tdata[35:30];
         got.second = rsp_tdata[41:36];
         got.usecs  = rsp_tdata[83:42];
         if (due_conversions.size() == 0) begin
            $display("%0t: unexpected word: expected none, got %0h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = due_conversions.pop_front();
            check_field("year",   64'(want.year),   64'(got.year));
            check_field("month",  64'(want.month),  64'(got.month));
            check_field("day",    64'(want.day),    64'(got.day));
            check_field("hour",   64'(want.hour),   64'(got.hour));
            check_field("minute", 64'(want.minute), 64'(got.minute));
            check_field("second", 64'(want.second), 64'(got.second));
            check_field("unix_seconds", 64'(want.usecs), 64'(got.usecs));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      conv_req_type it;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;

      queue_to_date(40'd0);
      queue_to_date(40'd1);
      queue_to_date(40'd59);
      queue_to_date(40'd86399);
      queue_to_date(40'd86400);
      queue_to_date(40'd951782400);      // leap day 2000
      queue_to_date(40'd4107542399);     // end of February 2100, not a leap year
      queue_to_date(40'd253402300799);
      queue_to_date(40'h7F_FFFF_FFFF);
      queue_to_date(40'hFF_FFFF_FFFF);   // negative, clamps to the epoch
      queue_to_date(40'h80_0000_0000);
      queue_to_secs(1970, 1, 1, 0, 0, 0);
      queue_to_secs(1969, 12, 31, 23, 59, 59);
      queue_to_secs(2000, 2, 29, 12, 34, 56);
      queue_to_secs(0, 0, 0, 0, 0, 0);
      queue_to_secs(0, 1, 1, 0, 0, 0);
      queue_to_secs(0, 2, 28, 0, 0, 0);
      queue_to_secs(2000, 0, 0, 23, 59, 59);  // month and day fields zero
      queue_to_secs(2000, 13, 1, 0, 0, 0);
      queue_to_secs(2000, 14, 1, 0, 0, 0);
      queue_to_secs(2000, 15, 31, 0, 0, 0);
      queue_to_secs(9999, 12, 31, 23, 59, 59);
      queue_to_secs(65535, 15, 31, 31, 63, 63);
      queue_to_secs(1, 3, 1, 0, 0, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         it = '{cmd_type'($urandom_range(0, 1)), {8'($urandom), $urandom}, 16'($urandom),
                4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom), 6'($urandom),
                (i == 0 || i == 700)};
         if ($urandom_range(0, 9) < 8) begin
            if (it.cmd == CMD_TO_DATE) begin
               it.secs[SECS_W-1] = 1'b0;
               if ($urandom_range(0, 1) == 1)
                  it.secs[SECS_W-1:32] = '0;
            end else begin
               it.year   = 16'($urandom_range(1, 9999));
               it.month  = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 12));
               it.day    = 5'($urandom_range(1, 31));
               it.hour   = 5'($urandom_range(0, 23));
               it.minute = 6'($urandom_range(0, 59));
               it.second = 6'($urandom_range(0, 59));
            end
         end
         queued_requests.push_back(it);
      end
      total_reqs = queued_requests.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt != total_reqs)
         @(posedge clock);
      while (due_conversions.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d words: %0d to date (%0d negative), %0d to seconds.",
               accepted_cnt, accepted_cnt - to_secs_cnt, negative_cnt, to_secs_cnt);
      $display("Checked %0d results; input held back for %0d cycles.",
               results_cnt, backpressure_cycles);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
